// ===== design/cln_pkg.sv =====
// Shared types, widths and constants of the conductance LIF neuron.
package cln_pkg;

	// Membrane potential and parameter widths (Q8.8 millivolts).
	localparam int POTENTIAL_WIDTH = 16;
	localparam int REG_W           = 16;
	localparam int REG_IDX_W       = 3;

	// Activity history window.
	localparam int HISTORY_DEPTH = 512;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int WIN_W         = 10;

	// Synapse accumulators saturate at 2^SUM_W - 1.
	localparam int              SUM_W   = 24;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Tick queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_AW        = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// Update datapath widths.
	localparam int DIFF_W    = POTENTIAL_WIDTH + 1;
	localparam int PROD_W    = SUM_W + 1 + DIFF_W;
	localparam int LEAK_M_W  = DIFF_W + 9;
	localparam int LEAK_SHIFT = LEAK_M_W;
	localparam logic [LEAK_SHIFT-1:0] LEAK_RECIP =
		LEAK_SHIFT'(((64'd1 << LEAK_SHIFT) + 64'd4) / 64'd5);
	localparam int NET_W       = PROD_W + 2;
	localparam int NET_LO_W    = NET_W / 2;
	localparam int NET_HI_W    = NET_W - NET_LO_W;
	localparam int RATE_W      = 16;
	localparam int FULL_W      = RATE_W + NET_W + 1;
	localparam int SCALE_SHIFT = 28;
	localparam int DELTA_W     = FULL_W - SCALE_SHIFT;
	localparam int VSUM_W      = DELTA_W + 1;
	localparam int REST_W      = 18;

	// Reset values of the configuration registers.
	localparam logic signed [REG_W-1:0] RESTING_RESET   = -16'sd17920;
	localparam logic signed [REG_W-1:0] THRESHOLD_RESET = -16'sd12800;
	localparam logic signed [REG_W-1:0] EXC_REV_RESET   = 16'sd0;
	localparam logic signed [REG_W-1:0] INH_REV_RESET   = -16'sd19200;
	localparam logic [REG_W-1:0]        RATE_RESET      = 16'd6554;
	localparam logic [REG_W-1:0]        DEPOL_RESET     = 16'd1;
	localparam logic [REG_W-1:0]        POL_RESET       = 16'd1;
	localparam logic [REG_W-1:0]        REFR_RESET      = 16'd2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RESTING   = 3'd0,
		REG_THRESHOLD = 3'd1,
		REG_EXC_REV   = 3'd2,
		REG_INH_REV   = 3'd3,
		REG_RATE      = 3'd4,
		REG_DEPOL     = 3'd5,
		REG_POL       = 3'd6,
		REG_REFR      = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic signed [REG_W-1:0] resting;
		logic signed [REG_W-1:0] threshold;
		logic signed [REG_W-1:0] exc_rev;
		logic signed [REG_W-1:0] inh_rev;
		logic [REG_W-1:0]        rate;
		logic [REG_W-1:0]        depol;
		logic [REG_W-1:0]        pol;
		logic [REG_W-1:0]        refr;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] excite;
		logic [SUM_W-1:0] inhibit;
	} tick_sums_t;

	typedef struct packed {
		logic                               activity_out;
		logic                               spike_fired;
		logic signed [POTENTIAL_WIDTH-1:0]  membrane_out;
		logic                               resting_flag;
		logic [WIN_W-1:0]                   window_ones;
		logic [WIN_W-1:0]                   window_fill;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_REST,
		BK_MUL,
		BK_NET,
		BK_SCALE,
		BK_ACC,
		BK_FIN
	} back_state_t;

endpackage

// ===== design/cln_ifs.sv =====
// Channel interfaces: synapse beats in, neuron update results out.
interface cln_syn_if;
	logic                    valid;
	logic                    ready;
	logic                    pre_active;
	logic signed [15:0]      syn_weight;
	logic                    tick_end;

	modport source (output valid, pre_active, syn_weight, tick_end, input ready);
	modport sink (input valid, pre_active, syn_weight, tick_end, output ready);
endinterface

interface cln_res_if;
	logic                    valid;
	logic                    ready;
	logic                    activity_out;
	logic                    spike_fired;
	logic signed [15:0]      membrane_out;
	logic                    resting_flag;
	logic [9:0]              window_ones;
	logic [9:0]              window_fill;

	modport source (output valid, activity_out, spike_fired, membrane_out, resting_flag,
		window_ones, window_fill, input ready);
	modport sink (input valid, activity_out, spike_fired, membrane_out, resting_flag,
		window_ones, window_fill, output ready);
endinterface

// ===== design/conductance_lif_neuron.sv =====
// Top level of the conductance-based leaky integrate-and-fire neuron.
//
// The synapse channel carries one synapse term per beat: the presynaptic
// activity bit, a signed Q4.12 weight and a tick_end flag. Beats without
// tick_end only accumulate and produce no result. The beat with tick_end
// closes the tick and produces exactly one beat on the result channel.
// Plain synapse beats are taken one per cycle while the queue has room. A
// tick end is handed through a two-entry queue to the update sequencer, which
// runs a membrane update (difference, multiply, sum, two partial products of
// the rate scaling, final add and saturate) or a rest step for a tick in
// post-spike rest; it takes no new tick until its result is registered, so
// it sets the sustained tick rate. If the receiver stalls, the result waits
// in the output register while the front keeps accepting synapse beats until
// the queue fills. Registers are written through write_en, reg_index and
// write_data while the block is idle, which the user, not the block, ensures.
// Reset loads the default parameters, sets the membrane to the resting
// potential and empties the sums, the queue and the activity window.
module conductance_lif_neuron (
	input  logic                              clk,
	input  logic                              arst_n,
	cln_syn_if.sink                           synapse,
	cln_res_if.source                         result,
	input  logic                              write_en,
	input  logic [cln_pkg::REG_IDX_W-1:0]     reg_index,
	input  logic [cln_pkg::REG_W-1:0]         write_data
);

	cln_pkg::cfg_t       cfg_q;
	logic                push_valid;
	logic                push_ready;
	cln_pkg::tick_sums_t push_data;
	logic                pop_valid;
	logic                pop_ready;
	cln_pkg::tick_sums_t pop_data;

	// Parameter registers; every index maps to one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resting   <= cln_pkg::RESTING_RESET;
			cfg_q.threshold <= cln_pkg::THRESHOLD_RESET;
			cfg_q.exc_rev   <= cln_pkg::EXC_REV_RESET;
			cfg_q.inh_rev   <= cln_pkg::INH_REV_RESET;
			cfg_q.rate      <= cln_pkg::RATE_RESET;
			cfg_q.depol     <= cln_pkg::DEPOL_RESET;
			cfg_q.pol       <= cln_pkg::POL_RESET;
			cfg_q.refr      <= cln_pkg::REFR_RESET;
		end else if (write_en) begin
			unique case (cln_pkg::reg_index_t'(reg_index))
				cln_pkg::REG_RESTING:   cfg_q.resting   <= write_data;
				cln_pkg::REG_THRESHOLD: cfg_q.threshold <= write_data;
				cln_pkg::REG_EXC_REV:   cfg_q.exc_rev   <= write_data;
				cln_pkg::REG_INH_REV:   cfg_q.inh_rev   <= write_data;
				cln_pkg::REG_RATE:      cfg_q.rate      <= write_data;
				cln_pkg::REG_DEPOL:     cfg_q.depol     <= write_data;
				cln_pkg::REG_POL:       cfg_q.pol       <= write_data;
				cln_pkg::REG_REFR:      cfg_q.refr      <= write_data;
				default: ;
			endcase
		end
	end

	// The front accumulates synapse terms and hands each finished tick to the queue.
	cln_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.synapse    (synapse),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cln_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back runs the membrane update and owns the result register.
	cln_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

// ===== design/cln_front.sv =====
// Front end: accepts synapse beats and accumulates the per-tick excitatory and inhibitory sums.
module cln_front (
	input  logic                clk,
	input  logic                arst_n,
	cln_syn_if.sink             synapse,
	output logic                push_valid,
	input  logic                push_ready,
	output cln_pkg::tick_sums_t push_data
);

	logic [cln_pkg::SUM_W-1:0] excite_q;
	logic [cln_pkg::SUM_W-1:0] inhibit_q;
	logic                      take;
	logic                      pos;
	logic [15:0]               mag;
	logic [15:0]               ex_add;
	logic [15:0]               in_add;
	logic [cln_pkg::SUM_W:0]   ex_sum;
	logic [cln_pkg::SUM_W:0]   in_sum;
	logic [cln_pkg::SUM_W-1:0] ex_next;
	logic [cln_pkg::SUM_W-1:0] in_next;

	// A beat is only taken when the queue could hold a finished tick.
	assign synapse.ready = push_ready;
	assign take          = synapse.valid && synapse.ready;

	always_comb begin
		pos    = synapse.syn_weight > 16'sd0;
		// Two's complement negation gives the right magnitude even for the most negative weight.
		mag    = pos ? synapse.syn_weight : 16'(~synapse.syn_weight + 16'd1);
		ex_add = (synapse.pre_active && pos) ? mag : 16'd0;
		in_add = (synapse.pre_active && !pos) ? mag : 16'd0;
		ex_sum = {1'b0, excite_q} + (cln_pkg::SUM_W + 1)'(ex_add);
		in_sum = {1'b0, inhibit_q} + (cln_pkg::SUM_W + 1)'(in_add);
		ex_next = ex_sum[cln_pkg::SUM_W] ? cln_pkg::SUM_MAX : ex_sum[cln_pkg::SUM_W-1:0];
		in_next = in_sum[cln_pkg::SUM_W] ? cln_pkg::SUM_MAX : in_sum[cln_pkg::SUM_W-1:0];
	end

	assign push_valid        = take && synapse.tick_end;
	assign push_data.excite  = ex_next;
	assign push_data.inhibit = in_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excite_q  <= '0;
			inhibit_q <= '0;
		end else if (take) begin
			if (synapse.tick_end) begin
				excite_q  <= '0;
				inhibit_q <= '0;
			end else begin
				excite_q  <= ex_next;
				inhibit_q <= in_next;
			end
		end
	end

endmodule

// ===== design/cln_queue.sv =====
// Short queue of finished tick sums between the front and the back.
module cln_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  cln_pkg::tick_sums_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output cln_pkg::tick_sums_t pop_data
);

	cln_pkg::tick_sums_t         entry_q [cln_pkg::QUEUE_DEPTH];
	logic [cln_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [cln_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [cln_pkg::Q_CNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = count_q != cln_pkg::Q_CNT_W'(cln_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == cln_pkg::Q_AW'(cln_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == cln_pkg::Q_AW'(cln_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/cln_back.sv =====
// Back end: membrane update sequencer, post-spike rest, activity history and result register.
module cln_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cln_pkg::cfg_t       cfg,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  cln_pkg::tick_sums_t pop_data,
	cln_res_if.source           result
);

	cln_pkg::back_state_t state_q;
	cln_pkg::back_state_t state_d;

	// Neuron state.
	logic signed [cln_pkg::POTENTIAL_WIDTH-1:0] membrane_q;
	logic [cln_pkg::REST_W-1:0]                 rest_left_q;
	logic                                       act_q;
	logic [cln_pkg::HIST_AW-1:0]                head_q;
	logic [cln_pkg::CNT_W-1:0]                  fill_q;
	logic [cln_pkg::CNT_W-1:0]                  ones_q;
	logic                                       ring_mem [cln_pkg::HISTORY_DEPTH];
	logic                                       old_bit_q;

	// Update pipeline.
	logic [cln_pkg::SUM_W-1:0]                  es_s1;
	logic [cln_pkg::SUM_W-1:0]                  is_s1;
	logic signed [cln_pkg::DIFF_W-1:0]          de_s1;
	logic signed [cln_pkg::DIFF_W-1:0]          di_s1;
	logic signed [cln_pkg::DIFF_W-1:0]          dl_s1;
	logic signed [cln_pkg::PROD_W-1:0]          pe_s2;
	logic signed [cln_pkg::PROD_W-1:0]          pi_s2;
	logic signed [cln_pkg::LEAK_M_W:0]          leak_s2;
	logic signed [cln_pkg::NET_W-1:0]           net_s3;
	logic [cln_pkg::RATE_W+cln_pkg::NET_LO_W-1:0]   plo_s4;
	logic signed [cln_pkg::RATE_W+cln_pkg::NET_HI_W:0] phi_s4;
	logic signed [cln_pkg::DELTA_W-1:0]         delta_s5;

	logic                                       out_valid_q;
	cln_pkg::result_t                           out_q;

	// Combinational helpers.
	logic                                       out_free;
	logic                                       emit;
	logic [cln_pkg::DIFF_W-1:0]                 dl_mag;
	logic [cln_pkg::LEAK_M_W+cln_pkg::LEAK_SHIFT-1:0] leak_prod;
	logic [cln_pkg::LEAK_M_W-1:0]               leak_q5;
	logic [cln_pkg::FULL_W-1:0]                 full_sum;
	logic signed [cln_pkg::VSUM_W-1:0]          vsum;
	logic signed [cln_pkg::VSUM_W-1:0]          v_hi;
	logic signed [cln_pkg::VSUM_W-1:0]          v_lo;
	logic signed [cln_pkg::POTENTIAL_WIDTH-1:0] v_sat;
	logic                                       upd_act;
	logic                                       upd_fire;
	logic [cln_pkg::REST_W-1:0]                 rest_load;
	logic [cln_pkg::REST_W-1:0]                 rest_dec;
	logic                                       rest_act;
	logic                                       ring_full;
	logic [cln_pkg::CNT_W-1:0]                  ones_next;
	logic [cln_pkg::CNT_W-1:0]                  fill_next;

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cln_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			cln_pkg::BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = (rest_left_q != '0) ? cln_pkg::BK_REST : cln_pkg::BK_MUL;
				end
			end
			cln_pkg::BK_REST: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = cln_pkg::BK_IDLE;
				end
			end
			cln_pkg::BK_MUL:   state_d = cln_pkg::BK_NET;
			cln_pkg::BK_NET:   state_d = cln_pkg::BK_SCALE;
			cln_pkg::BK_SCALE: state_d = cln_pkg::BK_ACC;
			cln_pkg::BK_ACC:   state_d = cln_pkg::BK_FIN;
			cln_pkg::BK_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = cln_pkg::BK_IDLE;
				end
			end
			default: state_d = cln_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		// Leak is (rest - V) * 512 / 5 truncated toward zero, done on the magnitude.
		dl_mag    = dl_s1[cln_pkg::DIFF_W-1] ? cln_pkg::DIFF_W'(-dl_s1) : cln_pkg::DIFF_W'(dl_s1);
		leak_prod = (cln_pkg::LEAK_M_W + cln_pkg::LEAK_SHIFT)'({dl_mag, 9'd0}) *
			(cln_pkg::LEAK_M_W + cln_pkg::LEAK_SHIFT)'(cln_pkg::LEAK_RECIP);
		leak_q5   = leak_prod[cln_pkg::LEAK_M_W+cln_pkg::LEAK_SHIFT-1:cln_pkg::LEAK_SHIFT];

		// Recombine the two partial products of rate * net.
		full_sum = (cln_pkg::FULL_W'(phi_s4) << cln_pkg::NET_LO_W) +
			cln_pkg::FULL_W'(plo_s4);

		vsum = cln_pkg::VSUM_W'(delta_s5) + cln_pkg::VSUM_W'(membrane_q);
		v_hi = cln_pkg::VSUM_W'((64'sd1 <<< (cln_pkg::POTENTIAL_WIDTH - 1)) - 64'sd1);
		v_lo = -v_hi - cln_pkg::VSUM_W'(1);
		if (vsum > v_hi) begin
			v_sat = cln_pkg::POTENTIAL_WIDTH'(v_hi);
		end else if (vsum < v_lo) begin
			v_sat = cln_pkg::POTENTIAL_WIDTH'(v_lo);
		end else begin
			v_sat = cln_pkg::POTENTIAL_WIDTH'(vsum);
		end
		upd_act  = v_sat >= cfg.threshold;
		upd_fire = v_sat > cfg.threshold;
		rest_load = cln_pkg::REST_W'(cfg.depol) + cln_pkg::REST_W'(cfg.pol) +
			cln_pkg::REST_W'(cfg.refr);

		rest_dec = rest_left_q - 1'b1;
		rest_act = (rest_dec < (cln_pkg::REST_W'(cfg.pol) + cln_pkg::REST_W'(cfg.refr))) ?
			1'b0 : act_q;

		ring_full = fill_q == cln_pkg::CNT_W'(cln_pkg::HISTORY_DEPTH);
		ones_next = ones_q - cln_pkg::CNT_W'(ring_full && old_bit_q) + cln_pkg::CNT_W'(upd_act);
		fill_next = ring_full ? fill_q : fill_q + 1'b1;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			membrane_q  <= cln_pkg::POTENTIAL_WIDTH'(cln_pkg::RESTING_RESET);
			rest_left_q <= '0;
			act_q       <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
			ones_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit && state_q == cln_pkg::BK_REST) begin
				rest_left_q <= rest_dec;
				act_q       <= rest_act;
			end
			if (emit && state_q == cln_pkg::BK_FIN) begin
				act_q      <= upd_act;
				membrane_q <= upd_fire ? cln_pkg::POTENTIAL_WIDTH'(cfg.resting) : v_sat;
				if (upd_fire) begin
					rest_left_q <= rest_load;
				end
				fill_q <= fill_next;
				ones_q <= ones_next;
				head_q <= (head_q == cln_pkg::HIST_AW'(cln_pkg::HISTORY_DEPTH - 1)) ?
					'0 : head_q + 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == cln_pkg::BK_IDLE) begin
			es_s1     <= pop_data.excite;
			is_s1     <= pop_data.inhibit;
			de_s1     <= cln_pkg::DIFF_W'(cfg.exc_rev) - cln_pkg::DIFF_W'(membrane_q);
			di_s1     <= cln_pkg::DIFF_W'(cfg.inh_rev) - cln_pkg::DIFF_W'(membrane_q);
			dl_s1     <= cln_pkg::DIFF_W'(cfg.resting) - cln_pkg::DIFF_W'(membrane_q);
			old_bit_q <= ring_mem[head_q];
		end
		if (state_q == cln_pkg::BK_MUL) begin
			pe_s2   <= $signed({1'b0, es_s1}) * de_s1;
			pi_s2   <= $signed({1'b0, is_s1}) * di_s1;
			leak_s2 <= dl_s1[cln_pkg::DIFF_W-1] ? -$signed({1'b0, leak_q5}) :
				$signed({1'b0, leak_q5});
		end
		if (state_q == cln_pkg::BK_NET) begin
			net_s3 <= cln_pkg::NET_W'(pe_s2) + cln_pkg::NET_W'(pi_s2) + cln_pkg::NET_W'(leak_s2);
		end
		if (state_q == cln_pkg::BK_SCALE) begin
			plo_s4 <= (cln_pkg::RATE_W + cln_pkg::NET_LO_W)'(cfg.rate) *
				(cln_pkg::RATE_W + cln_pkg::NET_LO_W)'(net_s3[cln_pkg::NET_LO_W-1:0]);
			phi_s4 <= $signed({1'b0, cfg.rate}) *
				$signed(net_s3[cln_pkg::NET_W-1:cln_pkg::NET_LO_W]);
		end
		if (state_q == cln_pkg::BK_ACC) begin
			// Taking the upper bits of a two's complement value is a floor shift.
			delta_s5 <= full_sum[cln_pkg::FULL_W-1:cln_pkg::SCALE_SHIFT];
		end
		if (emit) begin
			if (state_q == cln_pkg::BK_REST) begin
				out_q.activity_out <= rest_act;
				out_q.spike_fired  <= 1'b0;
				out_q.membrane_out <= membrane_q;
				out_q.resting_flag <= 1'b1;
				out_q.window_ones  <= cln_pkg::WIN_W'(ones_q);
				out_q.window_fill  <= cln_pkg::WIN_W'(fill_q);
			end else begin
				out_q.activity_out <= upd_act;
				out_q.spike_fired  <= upd_fire;
				out_q.membrane_out <= upd_fire ? cln_pkg::POTENTIAL_WIDTH'(cfg.resting) : v_sat;
				out_q.resting_flag <= 1'b0;
				out_q.window_ones  <= cln_pkg::WIN_W'(ones_next);
				out_q.window_fill  <= cln_pkg::WIN_W'(fill_next);
			end
		end
	end

	// Activity history ring.
	always_ff @(posedge clk) begin
		if (emit && state_q == cln_pkg::BK_FIN) begin
			ring_mem[head_q] <= upd_act;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.activity_out = out_q.activity_out;
	assign result.spike_fired  = out_q.spike_fired;
	assign result.membrane_out = out_q.membrane_out;
	assign result.resting_flag = out_q.resting_flag;
	assign result.window_ones  = out_q.window_ones;
	assign result.window_fill  = out_q.window_fill;

endmodule

// ===== design/cln_checker.sv =====
// Port-level checks on the result channel of the neuron, bound to the top level.
module cln_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        activity_out,
	input logic        spike_fired,
	input logic [15:0] membrane_out,
	input logic        resting_flag,
	input logic [9:0]  window_ones,
	input logic [9:0]  window_fill
);

	// A stalled result beat stays valid and keeps its membrane, window and spike fields.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(membrane_out) &&
		$stable(window_fill) && $stable(window_ones) && $stable(spike_fired))
		else $error("result beat changed while stalled");

	// A spike is only reported on an updated tick, and a spiking tick is active.
	a_spike: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && spike_fired |-> !resting_flag && activity_out)
		else $error("spike reported on a resting or inactive tick");

	// The window count never exceeds the fill, nor the fill the depth.
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> window_ones <= window_fill &&
		window_fill <= 10'(cln_pkg::HISTORY_DEPTH))
		else $error("activity window counts out of range");

endmodule

bind conductance_lif_neuron cln_checker u_cln_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.activity_out (result.activity_out),
	.spike_fired  (result.spike_fired),
	.membrane_out (result.membrane_out),
	.resting_flag (result.resting_flag),
	.window_ones  (result.window_ones),
	.window_fill  (result.window_fill)
);

// ===== bench/tb_conductance_lif_neuron.sv =====
// Self-checking testbench for the conductance-based LIF neuron: directed ticks, then random phases.
module tb_conductance_lif_neuron;

	// Weight extremes in Q4.12.
	localparam logic signed [15:0] W_MAX = 16'sh7fff;
	localparam logic signed [15:0] W_MIN = 16'sh8000;

	// Cycles to wait after the last expected update before touching registers.
	// The update path is a chain of registered steps, and plain synapse beats may
	// still sit in the front accumulators when the last update has come out.
	localparam int SETTLE_CYCLES = 30;

	// Random part: one long phase of single-beat ticks that overfills the
	// activity window, then shorter phases under varied register settings.
	localparam int RANDOM_PHASES = 5;
	localparam int RING_ITEMS    = 540;
	localparam int PHASE_ITEMS   = 95;

	// Beats needed to drive the excitatory accumulator into saturation in one tick.
	localparam int SAT_BEATS = 513;

	// Watchdog limit on the length of a run.
	localparam int unsigned CYCLE_LIMIT = 600000;

	// Expected-update tracker. It carries its own copy of the neuron state
	// and registers, accumulates every accepted synapse beat, steps the neuron
	// on each tick_end beat and queues the update that it produces.
	class neuron_scoreboard;
		cln_pkg::cfg_t                              cfg;
		logic signed [cln_pkg::POTENTIAL_WIDTH-1:0] membrane;
		logic [cln_pkg::SUM_W-1:0]                  excite_sum;
		logic [cln_pkg::SUM_W-1:0]                  inhibit_sum;
		logic [cln_pkg::REST_W-1:0]                 rest_left;
		bit                                         activity;
		bit                                         history [cln_pkg::HISTORY_DEPTH];
		int unsigned                                ring_head;
		int unsigned                                ring_fill;
		int unsigned                                ring_ones;
		cln_pkg::result_t                           updates_due[$];
		int unsigned                                errors;
		int unsigned                                beats;
		int unsigned                                updates;
		int unsigned                                spikes;
		int unsigned                                rest_ticks;
		int unsigned                                peak_fill;
		int unsigned                                reg_writes;

		function new(cln_pkg::cfg_t reset_cfg);
			cfg = reset_cfg;
			membrane = reset_cfg.resting;
			excite_sum = '0;
			inhibit_sum = '0;
			rest_left = '0;
			activity = 1'b0;
			foreach (history[i])
				history[i] = 1'b0;
			ring_head = 0;
			ring_fill = 0;
			ring_ones = 0;
			errors = 0;
			beats = 0;
			updates = 0;
			spikes = 0;
			rest_ticks = 0;
			peak_fill = 0;
			reg_writes = 0;
		endfunction

		function void set_reg(cln_pkg::reg_index_t idx, logic [cln_pkg::REG_W-1:0] val);
			reg_writes++;
			case (idx)
				cln_pkg::REG_RESTING:   cfg.resting = val;
				cln_pkg::REG_THRESHOLD: cfg.threshold = val;
				cln_pkg::REG_EXC_REV:   cfg.exc_rev = val;
				cln_pkg::REG_INH_REV:   cfg.inh_rev = val;
				cln_pkg::REG_RATE:      cfg.rate = val;
				cln_pkg::REG_DEPOL:     cfg.depol = val;
				cln_pkg::REG_POL:       cfg.pol = val;
				cln_pkg::REG_REFR:      cfg.refr = val;
			endcase
		endfunction

		function logic [cln_pkg::SUM_W-1:0] sat_add(logic [cln_pkg::SUM_W-1:0] a, longint b);
			longint s;
			s = longint'(a) + b;
			return (s > longint'(cln_pkg::SUM_MAX)) ? cln_pkg::SUM_MAX : s[cln_pkg::SUM_W-1:0];
		endfunction

		function void note_beat(bit pre, logic signed [15:0] w, bit te);
			longint           v;
			longint           net;
			longint           delta;
			longint           rp;
			longint           er;
			longint           ir;
			longint           thr;
			longint           v_hi;
			longint           v_lo;
			cln_pkg::result_t r;
			beats++;
			// Synapses only count outside the post-spike rest.
			if (rest_left == 0 && pre) begin
				if (w > 0)
					excite_sum = sat_add(excite_sum, longint'(w));
				else
					inhibit_sum = sat_add(inhibit_sum, -longint'(w));
			end
			if (!te)
				return;
			r.spike_fired = 1'b0;
			r.resting_flag = 1'b0;
			if (rest_left != 0) begin
				// Rest tick: count down, drop activity once past depolarization.
				rest_left = rest_left - 1'b1;
				if (int'(rest_left) < int'(cfg.pol) + int'(cfg.refr))
					activity = 1'b0;
				r.resting_flag = 1'b1;
				rest_ticks++;
			end else begin
				rp = longint'($signed(cfg.resting));
				er = longint'($signed(cfg.exc_rev));
				ir = longint'($signed(cfg.inh_rev));
				thr = longint'($signed(cfg.threshold));
				v = longint'(membrane);
				// Drive terms in Q.20; the leak is (rest - V)/40 rescaled.
				net = longint'(excite_sum) * (er - v) + longint'(inhibit_sum) * (ir - v)
					+ ((rp - v) * 512) / 5;
				delta = (longint'(cfg.rate) * net) >>> cln_pkg::SCALE_SHIFT;
				v_hi = (longint'(1) << (cln_pkg::POTENTIAL_WIDTH - 1)) - 1;
				v_lo = -v_hi - 1;
				v = v + delta;
				if (v > v_hi)
					v = v_hi;
				if (v < v_lo)
					v = v_lo;
				activity = (v >= thr);
				if (v > thr) begin
					v = rp;
					rest_left = cln_pkg::REST_W'(cfg.depol) + cln_pkg::REST_W'(cfg.pol) +
						cln_pkg::REST_W'(cfg.refr);
					r.spike_fired = 1'b1;
					spikes++;
				end
				membrane = v[cln_pkg::POTENTIAL_WIDTH-1:0];
				// Window push; once full, the oldest bit falls out.
				if (ring_fill >= cln_pkg::HISTORY_DEPTH)
					ring_ones -= history[ring_head];
				else
					ring_fill++;
				history[ring_head] = activity;
				ring_ones += activity;
				ring_head = (ring_head + 1) % cln_pkg::HISTORY_DEPTH;
				if (ring_fill > peak_fill)
					peak_fill = ring_fill;
			end
			excite_sum = '0;
			inhibit_sum = '0;
			r.activity_out = activity;
			r.membrane_out = membrane;
			r.window_ones = cln_pkg::WIN_W'(ring_ones);
			r.window_fill = cln_pkg::WIN_W'(ring_fill);
			updates_due = {updates_due, r};
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("update %0d %s: got %0h, expected %0h", updates, name, got,
					want));
		endtask

		task check_result(cln_pkg::result_t got);
			cln_pkg::result_t want;
			if (updates_due.size() == 0) begin
				report("update beat with no tick end waiting");
				return;
			end
			want = updates_due.pop_front();
			compare_field("activity_out", got.activity_out, want.activity_out);
			compare_field("spike_fired", got.spike_fired, want.spike_fired);
			compare_field("membrane_out", got.membrane_out, want.membrane_out);
			compare_field("resting_flag", got.resting_flag, want.resting_flag);
			compare_field("window_ones", got.window_ones, want.window_ones);
			compare_field("window_fill", got.window_fill, want.window_fill);
			updates++;
		endtask

		function int pending();
			return updates_due.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          write_en;
	logic [cln_pkg::REG_IDX_W-1:0] reg_index;
	logic [cln_pkg::REG_W-1:0]     write_data;

	cln_syn_if syn_ch ();
	cln_res_if res_ch ();

	neuron_scoreboard sb;

	// Traffic shaping knobs, changed between phases by the main sequence.
	bit          gaps_on = 1'b1;
	bit          stalls_on = 1'b1;
	int          burst_left = 0;
	int unsigned cycle_count = 0;

	conductance_lif_neuron dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.synapse    (syn_ch),
		.result     (res_ch),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a hung handshake or a lost update ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles with %0d updates outstanding", cycle_count,
			sb.pending());
		$display("Test completed with failures");
		$finish;
	end

	// Beat monitor. Everything is sampled at the rising edge, where the
	// testbench inputs have been stable since the falling edge. The result
	// side is checked first so that a stray update can never be matched
	// against a tick end accepted on the very same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result('{
					activity_out: res_ch.activity_out,
					spike_fired:  res_ch.spike_fired,
					membrane_out: res_ch.membrane_out,
					resting_flag: res_ch.resting_flag,
					window_ones:  res_ch.window_ones,
					window_fill:  res_ch.window_fill
				});
			if (syn_ch.valid && syn_ch.ready)
				sb.note_beat(syn_ch.pre_active, syn_ch.syn_weight, syn_ch.tick_end);
		end
	end

	// Result receiver. When stalls are enabled it alternates runs of ready
	// with runs of back-pressure of random length; otherwise it stays ready.
	initial begin
		bit ready_level;
		int ready_hold;
		ready_level = 1'b1;
		ready_hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold == 0) begin
				if (stalls_on && ready_level) begin
					ready_level = 1'b0;
					ready_hold = $urandom_range(1, 9);
				end else begin
					ready_level = 1'b1;
					ready_hold = $urandom_range(1, 14);
				end
			end else begin
				ready_hold--;
			end
			res_ch.ready <= ready_level;
		end
	end

	function automatic cln_pkg::cfg_t default_cfg();
		cln_pkg::cfg_t c;
		c.resting = cln_pkg::RESTING_RESET;
		c.threshold = cln_pkg::THRESHOLD_RESET;
		c.exc_rev = cln_pkg::EXC_REV_RESET;
		c.inh_rev = cln_pkg::INH_REV_RESET;
		c.rate = cln_pkg::RATE_RESET;
		c.depol = cln_pkg::DEPOL_RESET;
		c.pol = cln_pkg::POL_RESET;
		c.refr = cln_pkg::REFR_RESET;
		return c;
	endfunction

	// Either a plausible biological setting near -70 mV or a fully random
	// one. Rest phases stay short so that the neuron keeps integrating.
	function automatic cln_pkg::cfg_t random_cfg(bit wild);
		cln_pkg::cfg_t c;
		int            rest_mv;
		if (wild) begin
			c.resting = cln_pkg::REG_W'($urandom);
			c.threshold = cln_pkg::REG_W'($urandom);
			c.exc_rev = cln_pkg::REG_W'($urandom);
			c.inh_rev = cln_pkg::REG_W'($urandom);
			c.rate = cln_pkg::REG_W'($urandom);
		end else begin
			rest_mv = -17920 + int'($urandom_range(0, 2560)) - 1280;
			c.resting = cln_pkg::REG_W'(rest_mv);
			c.threshold = cln_pkg::REG_W'(rest_mv + int'($urandom_range(256, 6400)));
			c.exc_rev = cln_pkg::REG_W'(int'($urandom_range(0, 2560)) - 1280);
			c.inh_rev = cln_pkg::REG_W'(rest_mv - int'($urandom_range(0, 2560)));
			c.rate = cln_pkg::REG_W'($urandom_range(1000, 30000));
		end
		c.depol = cln_pkg::REG_W'($urandom_range(0, 3));
		c.pol = cln_pkg::REG_W'($urandom_range(0, 3));
		c.refr = cln_pkg::REG_W'($urandom_range(0, 3));
		return c;
	endfunction

	// Weight mix: extremes, zero, tiny values, moderate values of either
	// sign and fully random bit patterns.
	function automatic logic signed [15:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return W_MAX;
			1:       return W_MIN;
			2:       return 16'sh0000;
			3:       return 16'(int'($urandom_range(0, 64)) - 32);
			4, 5:    return 16'($urandom_range(0, 4095));
			6:       return 16'(-int'($urandom_range(0, 4095)));
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly short ticks so the window fills, with an occasional long one.
	function automatic int tick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 1;
		if (r < 9)
			return $urandom_range(2, 6);
		return $urandom_range(12, 30);
	endfunction

	task automatic write_reg(input cln_pkg::reg_index_t idx,
		input logic [cln_pkg::REG_W-1:0] val);
		write_en <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	// Writes all eight registers back to back; only called while idle.
	task automatic write_cfg(input cln_pkg::cfg_t c);
		write_reg(cln_pkg::REG_RESTING, c.resting);
		write_reg(cln_pkg::REG_THRESHOLD, c.threshold);
		write_reg(cln_pkg::REG_EXC_REV, c.exc_rev);
		write_reg(cln_pkg::REG_INH_REV, c.inh_rev);
		write_reg(cln_pkg::REG_RATE, c.rate);
		write_reg(cln_pkg::REG_DEPOL, c.depol);
		write_reg(cln_pkg::REG_POL, c.pol);
		write_reg(cln_pkg::REG_REFR, c.refr);
		write_en <= 1'b0;
	endtask

	// Presents one synapse beat and returns on the falling edge after it is
	// taken, with valid still high so back-to-back beats need no second
	// assignment in one step. At the start of a burst the sender may first
	// drop valid, when gaps are enabled, and put junk on the payload.
	task automatic send_beat(input bit pre, input logic signed [15:0] w, input bit te);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on)
				gap = $urandom_range(0, 7);
		end
		if (gap > 0) begin
			syn_ch.valid <= 1'b0;
			syn_ch.pre_active <= 1'($urandom);
			syn_ch.syn_weight <= 16'($urandom);
			syn_ch.tick_end <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		syn_ch.valid <= 1'b1;
		syn_ch.pre_active <= pre;
		syn_ch.syn_weight <= w;
		syn_ch.tick_end <= te;
		do
			@(posedge clk);
		while (syn_ch.ready !== 1'b1);
		@(negedge clk);
		burst_left--;
	endtask

	// One tick of random synapses, the last beat carrying tick_end.
	task automatic send_tick(input int len);
		for (int i = 0; i < len; i++)
			send_beat($urandom_range(0, 3) != 0, pick_weight(), i == len - 1);
	endtask

	// Runs out any post-spike rest with empty tick ends.
	task automatic clear_rest();
		while (sb.rest_left != 0)
			send_beat(1'b0, 16'sh0000, 1'b1);
	endtask

	// Stops sending, waits for every outstanding update, then lets the
	// pipeline drain before the next register change.
	task automatic finish_phase();
		syn_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		cln_pkg::cfg_t c;
		int            sent;
		int            len;
		sb = new(default_cfg());
		arst_n = 1'b0;
		write_en = 1'b0;
		reg_index = cln_pkg::REG_RESTING;
		write_data = '0;
		syn_ch.valid = 1'b0;
		syn_ch.pre_active = 1'b0;
		syn_ch.syn_weight = '0;
		syn_ch.tick_end = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset settings written back explicitly. A single
		// maximum excitatory beat fires the neuron and starts a four-tick
		// rest: one tick of held activity, then three with activity cleared.
		// Synapses during rest, including extreme and zero weights, must be
		// ignored.
		write_cfg(default_cfg());
		send_beat(1'b1, W_MAX, 1'b1);
		send_beat(1'b1, W_MIN, 1'b1);
		send_beat(1'b1, 16'sh0000, 1'b1);
		send_beat(1'b1, 16'sh0001, 1'b1);
		send_beat(1'b0, 16'shffff, 1'b1);
		// Out of rest: an inhibitory minimum weight, an inactive synapse and a
		// zero weight in one tick, then a small excitatory one.
		send_beat(1'b1, W_MIN, 1'b0);
		send_beat(1'b0, W_MAX, 1'b0);
		send_beat(1'b1, 16'sh0000, 1'b1);
		send_beat(1'b1, 16'sh0800, 1'b1);
		clear_rest();
		finish_phase();

		// Rate zero freezes V; with the threshold set to the stored V the
		// neuron is active without firing. The rest register moves too,
		// which must leave the stored V alone.
		c = default_cfg();
		c.rate = '0;
		c.threshold = sb.membrane;
		c.resting = 16'sh0000;
		write_cfg(c);
		send_beat(1'b1, 16'sh0000, 1'b1);
		send_beat(1'b1, W_MAX, 1'b1);
		finish_phase();

		// All phase lengths zero and the threshold at its minimum: each
		// update fires without starting any rest, until strong inhibition
		// pins V at the negative rail where it is active but cannot fire.
		c.resting = W_MAX;
		c.threshold = W_MIN;
		c.exc_rev = W_MAX;
		c.inh_rev = W_MIN;
		c.rate = 16'hffff;
		c.depol = '0;
		c.pol = '0;
		c.refr = '0;
		write_cfg(c);
		send_beat(1'b1, W_MAX, 1'b1);
		send_beat(1'b1, W_MIN, 1'b1);
		send_beat(1'b0, 16'sh0000, 1'b1);
		send_beat(1'b1, 16'sh1234, 1'b0);
		send_beat(1'b1, 16'shff00, 1'b1);
		finish_phase();

		// The other extremes: threshold at the positive rail, so V can reach
		// it but never exceed it, and the longest possible rest phases.
		c.resting = W_MIN;
		c.threshold = W_MAX;
		c.depol = 16'hffff;
		c.pol = 16'hffff;
		c.refr = 16'hffff;
		write_cfg(c);
		send_beat(1'b1, W_MAX, 1'b1);
		send_beat(1'b1, W_MIN, 1'b1);

		// Saturation: enough full-scale excitatory beats in one tick to pin
		// the excitatory sum at its maximum, back to back with no sender
		// gaps. The tick closes on the most negative weight.
		gaps_on = 1'b0;
		clear_rest();
		for (int i = 0; i < SAT_BEATS; i++)
			send_beat(1'b1, W_MAX, 1'b0);
		send_beat(1'b1, W_MIN, 1'b1);
		send_beat(1'b1, 16'sh0100, 1'b1);
		finish_phase();

		// Random phases. The first keeps the reset settings but without rest
		// and sends single-beat ticks only, so the activity window fills and
		// then wraps. The rest alternate plausible and wild register values,
		// with sender gaps and receiver stalls switched on and off.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				c = default_cfg();
				c.depol = '0;
				c.pol = '0;
				c.refr = '0;
			end else begin
				c = random_cfg(p % 2 == 0);
			end
			stalls_on = (p % 3 != 2);
			gaps_on = (p % 4 != 3);
			write_cfg(c);
			sent = 0;
			while (sent < ((p == 0) ? RING_ITEMS : PHASE_ITEMS)) begin
				len = (p == 0) ? 1 : tick_length();
				send_tick(len);
				sent += len;
			end
			finish_phase();
		end

		$display("Covered %0d synapse beats and %0d neuron updates: %0d spikes, %0d rest ticks.",
			sb.beats, sb.updates, sb.spikes, sb.rest_ticks);
		$display("Made %0d register writes; the activity window reached %0d of %0d entries.",
			sb.reg_writes, sb.peak_fill, cln_pkg::HISTORY_DEPTH);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/cln_pkg.sv
design/cln_ifs.sv
design/cln_front.sv
design/cln_queue.sv
design/cln_back.sv
design/conductance_lif_neuron.sv
design/cln_checker.sv
bench/tb_conductance_lif_neuron.sv
